/* rtl/gqt_pkg.sv */
`default_nettype none
package gqt_pkg;

	localparam int KEYWORD_COUNT   = 42;
	localparam int TABLE_ENTRIES   = 42;
	localparam int KEYWORD_MAX_LEN = 13;
	localparam int MAX_QUERY_BYTES = 65536;
	localparam int OFFSET_MAX      = (MAX_QUERY_BYTES - 1) < 65535 ? (MAX_QUERY_BYTES - 1) : 65535;
	localparam int KW_TEXT_BYTES   = 13;
	localparam int MAX_TOKENS      = 4;
	localparam int QUEUE_DEPTH     = 4;
	localparam int CNT_W           = $clog2(MAX_TOKENS + 1);

	localparam logic [16:0] SAT16   = 17'd65535;
	localparam logic [16:0] OFF_LIM = 17'(OFFSET_MAX);

	localparam logic [5:0] K_EOF    = 6'd0;
	localparam logic [5:0] K_ERR    = 6'd1;
	localparam logic [5:0] K_IDENT  = 6'd2;
	localparam logic [5:0] K_INT    = 6'd3;
	localparam logic [5:0] K_FLOAT  = 6'd4;
	localparam logic [5:0] K_STR    = 6'd5;
	localparam logic [5:0] K_PARAM  = 6'd6;
	localparam logic [5:0] K_NOT    = 6'd25;
	localparam logic [5:0] K_XOR    = 6'd26;
	localparam logic [5:0] K_LPAREN = 6'd32;
	localparam logic [5:0] K_RPAREN = 6'd33;
	localparam logic [5:0] K_LBRACK = 6'd34;
	localparam logic [5:0] K_RBRACK = 6'd35;
	localparam logic [5:0] K_LBRACE = 6'd36;
	localparam logic [5:0] K_RBRACE = 6'd37;
	localparam logic [5:0] K_COMMA  = 6'd38;
	localparam logic [5:0] K_SEMI   = 6'd39;
	localparam logic [5:0] K_COLON  = 6'd40;
	localparam logic [5:0] K_PIPE   = 6'd41;
	localparam logic [5:0] K_AT     = 6'd42;
	localparam logic [5:0] K_DOT    = 6'd43;
	localparam logic [5:0] K_STAR   = 6'd44;
	localparam logic [5:0] K_PLUS   = 6'd45;
	localparam logic [5:0] K_DIV    = 6'd46;
	localparam logic [5:0] K_MOD    = 6'd47;
	localparam logic [5:0] K_EQ     = 6'd48;
	localparam logic [5:0] K_NE     = 6'd49;
	localparam logic [5:0] K_LT     = 6'd50;
	localparam logic [5:0] K_LE     = 6'd51;
	localparam logic [5:0] K_GT     = 6'd52;
	localparam logic [5:0] K_GE     = 6'd53;
	localparam logic [5:0] K_ARROW  = 6'd54;
	localparam logic [5:0] K_MINUS  = 6'd55;

	typedef struct packed {
		logic [5:0]  kind;
		logic [15:0] offset;
		logic [15:0] length;
		logic [15:0] line;
		logic [15:0] column;
	} token_t;

	typedef struct packed {
		token_t [MAX_TOKENS-1:0] tok;
		logic [CNT_W-1:0]        cnt;
	} bundle_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_status_t;

	typedef struct packed {
		logic [8*KW_TEXT_BYTES-1:0] text;
		logic [4:0]                 len;
		logic [5:0]                 kind;
	} kw_entry_t;

	function automatic kw_entry_t kwe(logic [8*KW_TEXT_BYTES-1:0] t, int l, int kd);
		kw_entry_t r;
		r.text = t;
		r.len  = 5'(l);
		r.kind = 6'(kd);
		return r;
	endfunction

	function automatic kw_entry_t kw_entry(int k);
		kw_entry_t r;
		unique case (k)
			0: r = kwe("MATCH", 5, 7);
			1: r = kwe("RETURN", 6, 8);
			2: r = kwe("WHERE", 5, 9);
			3: r = kwe("CREATE", 6, 10);
			4: r = kwe("DELETE", 6, 11);
			5: r = kwe("SET", 3, 12);
			6: r = kwe("REMOVE", 6, 13);
			7: r = kwe("WITH", 4, 14);
			8: r = kwe("OPTIONAL", 8, 15);
			9: r = kwe("UNWIND", 6, 16);
			10: r = kwe("AS", 2, 17);
			11: r = kwe("DISTINCT", 8, 18);
			12: r = kwe("ORDER", 5, 19);
			13: r = kwe("BY", 2, 20);
			14: r = kwe("SKIP", 4, 21);
			15: r = kwe("LIMIT", 5, 22);
			16: r = kwe("AND", 3, 23);
			17: r = kwe("OR", 2, 24);
			18: r = kwe("NOT", 3, 25);
			19: r = kwe("XOR", 3, 26);
			20: r = kwe("NULL", 4, 27);
			21: r = kwe("TRUE", 4, 28);
			22: r = kwe("FALSE", 5, 29);
			23: r = kwe("count", 5, 30);
			24: r = kwe("sum", 3, 30);
			25: r = kwe("avg", 3, 30);
			26: r = kwe("min", 3, 30);
			27: r = kwe("max", 3, 30);
			28: r = kwe("collect", 7, 30);
			29: r = kwe("properties", 10, 31);
			30: r = kwe("type", 4, 31);
			31: r = kwe("labels", 6, 31);
			32: r = kwe("id", 2, 31);
			33: r = kwe("startNode", 9, 31);
			34: r = kwe("endNode", 7, 31);
			35: r = kwe("nodes", 5, 31);
			36: r = kwe("relationships", 13, 31);
			37: r = kwe("HEAD", 4, 31);
			38: r = kwe("TAIL", 4, 31);
			39: r = kwe("SIZE", 4, 31);
			40: r = kwe("EXISTS", 6, 31);
			41: r = kwe("COALESCE", 8, 31);
			default: r = kwe('0, 0, 0);
		endcase
		return r;
	endfunction

	function automatic logic [15:0] sat_lim(logic [15:0] a, logic [15:0] b, logic [16:0] lim);
		logic [16:0] s;
		s = {1'b0, a} + {1'b0, b};
		return (s > lim) ? lim[15:0] : s[15:0];
	endfunction

	function automatic token_t mk_tok(logic [5:0] kind, logic [15:0] off, logic [15:0] len,
			logic [15:0] line, logic [15:0] col);
		token_t t;
		t.kind   = kind;
		t.offset = off;
		t.length = len;
		t.line   = line;
		t.column = col;
		return t;
	endfunction

endpackage
`default_nettype wire

/* rtl/gqt_front.sv */
`default_nettype none
module gqt_front #(
	parameter int KEYWORD_COUNT = gqt_pkg::KEYWORD_COUNT
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             accept,
	input  wire logic [7:0]       in_byte,
	input  wire logic             byte_valid,
	input  wire logic             end_of_input,
	output gqt_pkg::bundle_t      bundle
);

	typedef enum logic [13:0] {
		M_IDLE    = 14'b00000000000001,
		M_SLASH   = 14'b00000000000010,
		M_COMMENT = 14'b00000000000100,
		M_IDENT   = 14'b00000000001000,
		M_PARAM   = 14'b00000000010000,
		M_MINUS   = 14'b00000000100000,
		M_INT     = 14'b00000001000000,
		M_INT_DOT = 14'b00000010000000,
		M_FLOAT   = 14'b00000100000000,
		M_STRING  = 14'b00001000000000,
		M_EQ      = 14'b00010000000000,
		M_BANG    = 14'b00100000000000,
		M_LT      = 14'b01000000000000,
		M_GT      = 14'b10000000000000
	} mode_t;

	localparam logic [KEYWORD_COUNT-1:0] ALL_HITS = '1;

	mode_t                    mode_q, mode_d;
	logic [15:0]              off_q, off_d, line_q, line_d, col_q, col_d;
	logic [15:0]              ts_q, ts_d, tl_q, tl_d, tln_q, tln_d, tc_q, tc_d;
	logic [KEYWORD_COUNT-1:0] hits_q, hits_d;
	logic                     quote_q, quote_d, esc_q, esc_d;

	function automatic logic is_alpha(logic [7:0] c);
		logic [7:0] l;
		l = c | 8'h20;
		return l >= 8'h61 && l <= 8'h7a;
	endfunction

	function automatic logic is_digit(logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic is_word(logic [7:0] c);
		return is_alpha(c) || is_digit(c) || c == 8'h5f;
	endfunction

	function automatic logic [KEYWORD_COUNT-1:0] hits_next(logic [KEYWORD_COUNT-1:0] h,
			logic [15:0] p, logic [7:0] c);
		gqt_pkg::kw_entry_t e;
		logic [KEYWORD_COUNT-1:0] r;
		int idx;
		r = h;
		for (int k = 0; k < KEYWORD_COUNT; k++) begin
			if (k < gqt_pkg::TABLE_ENTRIES) begin
				e = gqt_pkg::kw_entry(k);
				if (p >= 16'(gqt_pkg::KEYWORD_MAX_LEN) || p >= 16'(e.len)) begin
					r[k] = 1'b0;
				end else begin
					idx = 8 * (int'(e.len) - 1 - int'(p[4:0]));
					if (e.text[idx +: 8] != c) r[k] = 1'b0;
				end
			end
		end
		return r;
	endfunction

	function automatic logic [5:0] ident_kind(logic [KEYWORD_COUNT-1:0] h, logic [15:0] len);
		gqt_pkg::kw_entry_t e;
		logic [5:0] kd;
		kd = gqt_pkg::K_IDENT;
		for (int k = KEYWORD_COUNT - 1; k >= 0; k--) begin
			if (k < gqt_pkg::TABLE_ENTRIES) begin
				e = gqt_pkg::kw_entry(k);
				if (h[k] && 16'(e.len) == len) kd = e.kind;
			end
		end
		return kd;
	endfunction

	always_comb begin
		gqt_pkg::token_t [gqt_pkg::MAX_TOKENS-1:0] tk;
		logic [gqt_pkg::CNT_W-1:0] n;
		logic consumed;
		logic [7:0] c;
		logic [7:0] qc;
		tk = '0;
		n = '0;
		consumed = 1'b0;
		c = in_byte;
		mode_d = mode_q;
		off_d = off_q;
		line_d = line_q;
		col_d = col_q;
		ts_d = ts_q;
		tl_d = tl_q;
		tln_d = tln_q;
		tc_d = tc_q;
		hits_d = hits_q;
		quote_d = quote_q;
		esc_d = esc_q;
		qc = quote_q ? 8'h22 : 8'h27;
		if (byte_valid) begin
			unique case (mode_q)
				M_IDLE: consumed = 1'b0;
				M_SLASH: begin
					if (c == 8'h2f) begin
						mode_d = M_COMMENT;
						consumed = 1'b1;
					end else begin
						tk[n[1:0]] = gqt_pkg::mk_tok(gqt_pkg::K_DIV, ts_d, tl_d, tln_d, tc_d);
						n = n + 1'b1;
					end
				end
				M_COMMENT: begin
					if (c == 8'h0a) mode_d = M_IDLE;
					consumed = 1'b1;
				end
				M_IDENT: begin
					if (is_word(c)) begin
						hits_d = hits_next(hits_q, tl_q, c);
						tl_d = gqt_pkg::sat_lim(tl_q, 16'd1, gqt_pkg::SAT16);
						consumed = 1'b1;
					end else begin
						tk[n[1:0]] = gqt_pkg::mk_tok(ident_kind(hits_q, tl_q), ts_d, tl_d,
							tln_d, tc_d);
						n = n + 1'b1;
					end
				end
				M_PARAM: begin
					if (is_word(c)) begin
						tl_d = gqt_pkg::sat_lim(tl_q, 16'd1, gqt_pkg::SAT16);
						consumed = 1'b1;
					end else begin
						tk[n[1:0]] = gqt_pkg::mk_tok(gqt_pkg::K_PARAM, ts_d, tl_d, tln_d, tc_d);
						n = n + 1'b1;
					end
				end
				M_MINUS: begin
					if (is_digit(c)) begin
						tl_d = 16'd2;
						mode_d = M_INT;
						consumed = 1'b1;
					end else if (c == 8'h3e) begin
						tl_d = 16'd2;
						tk[n[1:0]] = gqt_pkg::mk_tok(gqt_pkg::K_ARROW, ts_d, tl_d, tln_d, tc_d);
						n = n + 1'b1;
						mode_d = M_IDLE;
						consumed = 1'b1;
					end else begin
						tk[n[1:0]] = gqt_pkg::mk_tok(gqt_pkg::K_MINUS, ts_d, tl_d, tln_d, tc_d);
						n = n + 1'b1;
					end
				end
				M_INT: begin
					if (is_digit(c)) begin
						tl_d = gqt_pkg::sat_lim(tl_q, 16'd1, gqt_pkg::SAT16);
						consumed = 1'b1;
					end else if (c == 8'h2e) begin
						mode_d = M_INT_DOT;
						consumed = 1'b1;
					end else begin
						tk[n[1:0]] = gqt_pkg::mk_tok(gqt_pkg::K_INT, ts_d, tl_d, tln_d, tc_d);
						n = n + 1'b1;
					end
				end
				M_INT_DOT: begin
					if (is_digit(c)) begin
						tl_d = gqt_pkg::sat_lim(tl_q, 16'd2, gqt_pkg::SAT16);
						mode_d = M_FLOAT;
						consumed = 1'b1;
					end else begin
						tk[n[1:0]] = gqt_pkg::mk_tok(gqt_pkg::K_INT, ts_d, tl_d, tln_d, tc_d);
						n = n + 1'b1;
						tk[n[1:0]] = gqt_pkg::mk_tok(gqt_pkg::K_DOT,
							gqt_pkg::sat_lim(ts_d, tl_d, gqt_pkg::OFF_LIM), 16'd1, tln_d,
							gqt_pkg::sat_lim(tc_d, tl_d, gqt_pkg::SAT16));
						n = n + 1'b1;
					end
				end
				M_FLOAT: begin
					if (is_digit(c)) begin
						tl_d = gqt_pkg::sat_lim(tl_q, 16'd1, gqt_pkg::SAT16);
						consumed = 1'b1;
					end else begin
						tk[n[1:0]] = gqt_pkg::mk_tok(gqt_pkg::K_FLOAT, ts_d, tl_d, tln_d, tc_d);
						n = n + 1'b1;
					end
				end
				M_STRING: begin
					consumed = 1'b1;
					if (c == qc && !esc_q) begin
						tk[n[1:0]] = gqt_pkg::mk_tok(gqt_pkg::K_STR,
							gqt_pkg::sat_lim(ts_q, 16'd1, gqt_pkg::OFF_LIM), tl_q, tln_q,
							gqt_pkg::sat_lim(tc_q, 16'd1, gqt_pkg::SAT16));
						n = n + 1'b1;
						mode_d = M_IDLE;
					end else begin
						esc_d = (c == 8'h5c);
						tl_d = gqt_pkg::sat_lim(tl_q, 16'd1, gqt_pkg::SAT16);
					end
				end
				M_EQ: begin
					if (c == 8'h3d) begin
						tl_d = 16'd2;
						mode_d = M_IDLE;
						consumed = 1'b1;
					end
					tk[n[1:0]] = gqt_pkg::mk_tok(gqt_pkg::K_EQ, ts_d, tl_d, tln_d, tc_d);
					n = n + 1'b1;
				end
				M_BANG: begin
					if (c == 8'h3d) begin
						tl_d = 16'd2;
						tk[n[1:0]] = gqt_pkg::mk_tok(gqt_pkg::K_NE, ts_d, tl_d, tln_d, tc_d);
						mode_d = M_IDLE;
						consumed = 1'b1;
					end else begin
						tk[n[1:0]] = gqt_pkg::mk_tok(gqt_pkg::K_NOT, ts_d, tl_d, tln_d, tc_d);
					end
					n = n + 1'b1;
				end
				M_LT: begin
					if (c == 8'h3d || c == 8'h2d) begin
						tl_d = 16'd2;
						tk[n[1:0]] = gqt_pkg::mk_tok((c == 8'h3d) ? gqt_pkg::K_LE : gqt_pkg::K_ARROW,
							ts_d, tl_d, tln_d, tc_d);
						mode_d = M_IDLE;
						consumed = 1'b1;
					end else begin
						tk[n[1:0]] = gqt_pkg::mk_tok(gqt_pkg::K_LT, ts_d, tl_d, tln_d, tc_d);
					end
					n = n + 1'b1;
				end
				M_GT: begin
					if (c == 8'h3d) begin
						tl_d = 16'd2;
						tk[n[1:0]] = gqt_pkg::mk_tok(gqt_pkg::K_GE, ts_d, tl_d, tln_d, tc_d);
						mode_d = M_IDLE;
						consumed = 1'b1;
					end else begin
						tk[n[1:0]] = gqt_pkg::mk_tok(gqt_pkg::K_GT, ts_d, tl_d, tln_d, tc_d);
					end
					n = n + 1'b1;
				end
				default: consumed = 1'b0;
			endcase

			if (!consumed) begin
				mode_d = M_IDLE;
				if (c == 8'h20 || c == 8'h09 || c == 8'h0d || c == 8'h0a) begin
					mode_d = M_IDLE;
				end else if (is_alpha(c) || c == 8'h5f || is_digit(c) || c == 8'h27 ||
						c == 8'h22 || c == 8'h2f || c == 8'h2d || c == 8'h24 || c == 8'h3d ||
						c == 8'h21 || c == 8'h3c || c == 8'h3e) begin
					ts_d = off_q;
					tln_d = line_q;
					tc_d = col_q;
					tl_d = 16'd1;
					if (is_alpha(c) || c == 8'h5f) begin
						mode_d = M_IDENT;
						hits_d = hits_next(ALL_HITS, 16'd0, c);
					end else if (is_digit(c)) begin
						mode_d = M_INT;
					end else if (c == 8'h27 || c == 8'h22) begin
						mode_d = M_STRING;
						tl_d = 16'd0;
						quote_d = (c == 8'h22);
						esc_d = 1'b0;
					end else if (c == 8'h2f) begin
						mode_d = M_SLASH;
					end else if (c == 8'h2d) begin
						mode_d = M_MINUS;
					end else if (c == 8'h24) begin
						mode_d = M_PARAM;
					end else if (c == 8'h3d) begin
						mode_d = M_EQ;
					end else if (c == 8'h21) begin
						mode_d = M_BANG;
					end else if (c == 8'h3c) begin
						mode_d = M_LT;
					end else begin
						mode_d = M_GT;
					end
				end else begin
					logic [5:0] sk;
					unique case (c)
						8'h28: sk = gqt_pkg::K_LPAREN;
						8'h29: sk = gqt_pkg::K_RPAREN;
						8'h5b: sk = gqt_pkg::K_LBRACK;
						8'h5d: sk = gqt_pkg::K_RBRACK;
						8'h7b: sk = gqt_pkg::K_LBRACE;
						8'h7d: sk = gqt_pkg::K_RBRACE;
						8'h2c: sk = gqt_pkg::K_COMMA;
						8'h3b: sk = gqt_pkg::K_SEMI;
						8'h3a: sk = gqt_pkg::K_COLON;
						8'h7c: sk = gqt_pkg::K_PIPE;
						8'h40: sk = gqt_pkg::K_AT;
						8'h2e: sk = gqt_pkg::K_DOT;
						8'h2a: sk = gqt_pkg::K_STAR;
						8'h2b: sk = gqt_pkg::K_PLUS;
						8'h25: sk = gqt_pkg::K_MOD;
						8'h5e: sk = gqt_pkg::K_XOR;
						default: sk = gqt_pkg::K_ERR;
					endcase
					tk[n[1:0]] = gqt_pkg::mk_tok(sk, off_q, 16'd1, line_q, col_q);
					n = n + 1'b1;
				end
			end

			off_d = gqt_pkg::sat_lim(off_q, 16'd1, gqt_pkg::OFF_LIM);
			if (c == 8'h0a) begin
				line_d = gqt_pkg::sat_lim(line_q, 16'd1, gqt_pkg::SAT16);
				col_d = 16'd1;
			end else begin
				col_d = gqt_pkg::sat_lim(col_q, 16'd1, gqt_pkg::SAT16);
			end
		end

		if (end_of_input) begin
			unique case (mode_d)
				M_IDLE, M_COMMENT: consumed = consumed;
				M_SLASH: begin
					tk[n[1:0]] = gqt_pkg::mk_tok(gqt_pkg::K_DIV, ts_d, tl_d, tln_d, tc_d);
					n = n + 1'b1;
				end
				M_IDENT: begin
					tk[n[1:0]] = gqt_pkg::mk_tok(ident_kind(hits_d, tl_d), ts_d, tl_d,
						tln_d, tc_d);
					n = n + 1'b1;
				end
				M_PARAM: begin
					tk[n[1:0]] = gqt_pkg::mk_tok(gqt_pkg::K_PARAM, ts_d, tl_d, tln_d, tc_d);
					n = n + 1'b1;
				end
				M_MINUS: begin
					tk[n[1:0]] = gqt_pkg::mk_tok(gqt_pkg::K_MINUS, ts_d, tl_d, tln_d, tc_d);
					n = n + 1'b1;
				end
				M_INT: begin
					tk[n[1:0]] = gqt_pkg::mk_tok(gqt_pkg::K_INT, ts_d, tl_d, tln_d, tc_d);
					n = n + 1'b1;
				end
				M_INT_DOT: begin
					tk[n[1:0]] = gqt_pkg::mk_tok(gqt_pkg::K_INT, ts_d, tl_d, tln_d, tc_d);
					n = n + 1'b1;
					tk[n[1:0]] = gqt_pkg::mk_tok(gqt_pkg::K_DOT,
						gqt_pkg::sat_lim(ts_d, tl_d, gqt_pkg::OFF_LIM), 16'd1, tln_d,
						gqt_pkg::sat_lim(tc_d, tl_d, gqt_pkg::SAT16));
					n = n + 1'b1;
				end
				M_FLOAT: begin
					tk[n[1:0]] = gqt_pkg::mk_tok(gqt_pkg::K_FLOAT, ts_d, tl_d, tln_d, tc_d);
					n = n + 1'b1;
				end
				M_STRING: begin
					tk[n[1:0]] = gqt_pkg::mk_tok(gqt_pkg::K_ERR, ts_d,
						gqt_pkg::sat_lim(tl_d, 16'd1, gqt_pkg::SAT16), tln_d, tc_d);
					n = n + 1'b1;
				end
				M_EQ: begin
					tk[n[1:0]] = gqt_pkg::mk_tok(gqt_pkg::K_EQ, ts_d, tl_d, tln_d, tc_d);
					n = n + 1'b1;
				end
				M_BANG: begin
					tk[n[1:0]] = gqt_pkg::mk_tok(gqt_pkg::K_NOT, ts_d, tl_d, tln_d, tc_d);
					n = n + 1'b1;
				end
				M_LT: begin
					tk[n[1:0]] = gqt_pkg::mk_tok(gqt_pkg::K_LT, ts_d, tl_d, tln_d, tc_d);
					n = n + 1'b1;
				end
				M_GT: begin
					tk[n[1:0]] = gqt_pkg::mk_tok(gqt_pkg::K_GT, ts_d, tl_d, tln_d, tc_d);
					n = n + 1'b1;
				end
				default: consumed = consumed;
			endcase
			tk[n[1:0]] = gqt_pkg::mk_tok(gqt_pkg::K_EOF, off_d, 16'd0, line_d, col_d);
			n = n + 1'b1;
			mode_d = M_IDLE;
			off_d = 16'd0;
			line_d = 16'd1;
			col_d = 16'd1;
			ts_d = 16'd0;
			tl_d = 16'd0;
			tln_d = 16'd1;
			tc_d = 16'd1;
			hits_d = ALL_HITS;
			quote_d = 1'b0;
			esc_d = 1'b0;
		end
		bundle.tok = tk;
		bundle.cnt = n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			off_q <= 16'd0;
			line_q <= 16'd1;
			col_q <= 16'd1;
			ts_q <= 16'd0;
			tl_q <= 16'd0;
			tln_q <= 16'd1;
			tc_q <= 16'd1;
			hits_q <= ALL_HITS;
			quote_q <= 1'b0;
			esc_q <= 1'b0;
		end else if (accept) begin
			mode_q <= mode_d;
			off_q <= off_d;
			line_q <= line_d;
			col_q <= col_d;
			ts_q <= ts_d;
			tl_q <= tl_d;
			tln_q <= tln_d;
			tc_q <= tc_d;
			hits_q <= hits_d;
			quote_q <= quote_d;
			esc_q <= esc_d;
		end
	end

endmodule
`default_nettype wire

/* rtl/gqt_fifo.sv */
`default_nettype none
module gqt_fifo (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  wr_en,
	input  wire gqt_pkg::bundle_t      wr_data,
	input  wire logic                  rd_en,
	output gqt_pkg::bundle_t           rd_data,
	output gqt_pkg::fifo_status_t      status
);

	localparam int DEPTH = gqt_pkg::QUEUE_DEPTH;
	localparam int PW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);

	gqt_pkg::bundle_t mem_q [DEPTH];
	logic [PW-1:0]    wp_q, rp_q;
	logic [CW-1:0]    cnt_q;

	assign rd_data      = mem_q[rp_q];
	assign status.full  = (cnt_q == CW'(DEPTH));
	assign status.empty = (cnt_q == '0);

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en) wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			if (rd_en) rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			if (wr_en && !rd_en) cnt_q <= cnt_q + 1'b1;
			else if (rd_en && !wr_en) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule
`default_nettype wire

/* rtl/gqt_back.sv */
`default_nettype none
module gqt_back (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire gqt_pkg::bundle_t      head,
	input  wire gqt_pkg::fifo_status_t status,
	input  wire logic                  pop,
	output logic                       deq,
	output logic [5:0]                 token_kind,
	output logic [15:0]                token_offset,
	output logic [15:0]                token_length,
	output logic [15:0]                token_line,
	output logic [15:0]                token_column,
	output logic                       last_of_run
);

	localparam int IW = $clog2(gqt_pkg::MAX_TOKENS);

	logic [IW-1:0]   idx_q;
	gqt_pkg::token_t cur;

	assign cur          = head.tok[idx_q];
	assign token_kind   = cur.kind;
	assign token_offset = cur.offset;
	assign token_length = cur.length;
	assign token_line   = cur.line;
	assign token_column = cur.column;
	assign last_of_run  = ({1'b0, idx_q} + 1'b1) == gqt_pkg::CNT_W'(head.cnt);
	assign deq          = pop && !status.empty && last_of_run;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (pop && !status.empty) begin
			idx_q <= last_of_run ? '0 : idx_q + 1'b1;
		end
	end

endmodule
`default_nettype wire

/* rtl/graph_query_tokenizer.sv */
`default_nettype none
// Streaming lexer for a graph query language, one text byte per item. An item is taken every
// cycle while full is low; the lexer state updates in that cycle and the tokens the item closes
// (up to four, the last flagged by last_of_run) go as one group into a four-deep queue. Tokens
// leave one per cycle on pop while empty is low, and a group leaves the queue only with its
// last token; full rises only once four such groups wait. end_of_input flushes the open
// token, emits EOF and returns offset, line and column to their start values.
module graph_query_tokenizer #(
	parameter int KEYWORD_COUNT = gqt_pkg::KEYWORD_COUNT
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [7:0]  in_byte,
	input  wire logic        byte_valid,
	input  wire logic        end_of_input,
	output logic             empty,
	input  wire logic        pop,
	output logic [5:0]       token_kind,
	output logic [15:0]      token_offset,
	output logic [15:0]      token_length,
	output logic [15:0]      token_line,
	output logic [15:0]      token_column,
	output logic             last_of_run
);

	gqt_pkg::bundle_t      bundle, head;
	gqt_pkg::fifo_status_t status;
	logic                  accept, deq;

	assign accept = push && !full;
	assign full   = status.full;
	assign empty  = status.empty;

	gqt_front #(.KEYWORD_COUNT(KEYWORD_COUNT)) u_front (
		.clk, .arst_n, .accept, .in_byte, .byte_valid, .end_of_input, .bundle
	);

	gqt_fifo u_fifo (
		.clk, .arst_n, .wr_en(accept && bundle.cnt != '0), .wr_data(bundle),
		.rd_en(deq), .rd_data(head), .status
	);

	gqt_back u_back (
		.clk, .arst_n, .head, .status, .pop, .deq, .token_kind, .token_offset,
		.token_length, .token_line, .token_column, .last_of_run
	);

	a_full_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !empty) else $error("queue full but empty flag set");

	a_eof_queued: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full && end_of_input) |=> !empty) else $error("end of input left no item");

	a_group_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> head.cnt != '0) else $error("empty token group in queue");

endmodule
`default_nettype wire

/* tb/tb_graph_query_tokenizer.sv */
`timescale 1ns / 1ps
module tb_graph_query_tokenizer;

	typedef enum logic [3:0] {
		LX_IDLE, LX_SLASH, LX_COMMENT, LX_IDENT, LX_PARAM, LX_MINUS, LX_INT,
		LX_INT_DOT, LX_FLOAT, LX_STRING, LX_EQ, LX_BANG, LX_LT, LX_GT
	} lex_mode_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       valid;
		logic       fin;
	} text_item_t;

	typedef struct packed {
		logic [5:0]  kind;
		logic [15:0] offset;
		logic [15:0] length;
		logic [15:0] line;
		logic [15:0] column;
		logic        last;
	} lex_token_t;

	logic clk, arst_n, push, full, empty, pop, byte_valid, end_of_input, last_of_run;
	logic [7:0] in_byte;
	logic [5:0] token_kind;
	logic [15:0] token_offset, token_length, token_line, token_column;

	graph_query_tokenizer u_dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .in_byte(in_byte),
		.byte_valid(byte_valid), .end_of_input(end_of_input), .empty(empty), .pop(pop),
		.token_kind(token_kind), .token_offset(token_offset), .token_length(token_length),
		.token_line(token_line), .token_column(token_column), .last_of_run(last_of_run)
	);

	text_item_t pending_items[$];
	lex_token_t token_queue[$];
	int errors = 0;
	int cycles = 0;
	bit quiet = 0;
	bit hold_push = 0;
	bit took = 0;
	int gap_left = 0, stall_left = 0;

	// lexer shadow state
	lex_mode_t m_mode;
	logic [15:0] m_off, m_line, m_col, m_start, m_len, m_tline, m_tcol;
	logic [41:0] m_hits;
	logic m_dq, m_esc;
	lex_token_t m_out[$];

	function automatic logic [15:0] sat(logic [15:0] a, logic [15:0] b, logic [16:0] lim);
		logic [16:0] s;
		s = {1'b0, a} + {1'b0, b};
		return (s > lim) ? lim[15:0] : s[15:0];
	endfunction

	function automatic string kw_name(int k);
		string names[42] = '{"MATCH", "RETURN", "WHERE", "CREATE", "DELETE", "SET", "REMOVE",
			"WITH", "OPTIONAL", "UNWIND", "AS", "DISTINCT", "ORDER", "BY", "SKIP", "LIMIT",
			"AND", "OR", "NOT", "XOR", "NULL", "TRUE", "FALSE", "count", "sum", "avg", "min",
			"max", "collect", "properties", "type", "labels", "id", "startNode", "endNode",
			"nodes", "relationships", "HEAD", "TAIL", "SIZE", "EXISTS", "COALESCE"};
		return names[k];
	endfunction

	function automatic logic [5:0] kw_kind(int k);
		if (k < 23) return 6'(k + 7);
		if (k < 29) return 6'd30;
		return 6'd31;
	endfunction

	function automatic bit is_alpha(logic [7:0] c);
		logic [7:0] l;
		l = c | 8'h20;
		return l >= "a" && l <= "z";
	endfunction

	function automatic bit is_digit(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit is_word(logic [7:0] c);
		return is_alpha(c) || is_digit(c) || c == "_";
	endfunction

	task automatic lex_reset();
		m_mode = LX_IDLE; m_off = 0; m_line = 1; m_col = 1; m_start = 0; m_len = 0;
		m_tline = 1; m_tcol = 1; m_hits = '1; m_dq = 0; m_esc = 0;
	endtask

	function automatic void add_token(logic [5:0] k, logic [15:0] o, logic [15:0] l,
			logic [15:0] ln, logic [15:0] c);
		lex_token_t t;
		t = '{k, o, l, ln, c, 1'b0};
		if (m_out.size() < gqt_pkg::MAX_TOKENS) m_out.push_back(t);
	endfunction

	function automatic void add_open(logic [5:0] k);
		add_token(k, m_start, m_len, m_tline, m_tcol);
	endfunction

	function automatic void narrow_hits(logic [7:0] c);
		string s;
		for (int k = 0; k < 42; k++) begin
			s = kw_name(k);
			if (m_hits[k] && (m_len >= gqt_pkg::KEYWORD_MAX_LEN || m_len >= s.len() ||
					s[m_len] != c))
				m_hits[k] = 0;
		end
	endfunction

	function automatic logic [5:0] word_kind();
		for (int k = 0; k < 42; k++)
			if (m_hits[k] && kw_name(k).len() == m_len) return kw_kind(k);
		return gqt_pkg::K_IDENT;
	endfunction

	function automatic void open_token(lex_mode_t md);
		m_start = m_off; m_tline = m_line; m_tcol = m_col; m_len = 1; m_mode = md;
	endfunction

	function automatic void int_and_dot();
		add_open(gqt_pkg::K_INT);
		add_token(gqt_pkg::K_DOT, sat(m_start, m_len, gqt_pkg::OFF_LIM), 1, m_tline,
			sat(m_tcol, m_len, gqt_pkg::SAT16));
	endfunction

	task automatic scan_fresh(logic [7:0] c);
		logic [5:0] k;
		m_mode = LX_IDLE;
		if (c == " " || c == "\t" || c == "\r" || c == "\n") return;
		if (is_alpha(c) || c == "_") begin
			open_token(LX_IDENT);
			m_hits = '1; m_len = 0; narrow_hits(c); m_len = 1;
			return;
		end
		if (is_digit(c)) begin
			open_token(LX_INT);
			return;
		end
		if (c == "'" || c == "\"") begin
			open_token(LX_STRING); m_len = 0; m_dq = (c == "\""); m_esc = 0;
			return;
		end
		case (c)
			"/": begin open_token(LX_SLASH); return; end
			"-": begin open_token(LX_MINUS); return; end
			"$": begin open_token(LX_PARAM); return; end
			"=": begin open_token(LX_EQ); return; end
			"!": begin open_token(LX_BANG); return; end
			"<": begin open_token(LX_LT); return; end
			">": begin open_token(LX_GT); return; end
			"(": k = gqt_pkg::K_LPAREN;
			")": k = gqt_pkg::K_RPAREN;
			"[": k = gqt_pkg::K_LBRACK;
			"]": k = gqt_pkg::K_RBRACK;
			"{": k = gqt_pkg::K_LBRACE;
			"}": k = gqt_pkg::K_RBRACE;
			",": k = gqt_pkg::K_COMMA;
			";": k = gqt_pkg::K_SEMI;
			":": k = gqt_pkg::K_COLON;
			"|": k = gqt_pkg::K_PIPE;
			"@": k = gqt_pkg::K_AT;
			".": k = gqt_pkg::K_DOT;
			"*": k = gqt_pkg::K_STAR;
			"+": k = gqt_pkg::K_PLUS;
			"%": k = gqt_pkg::K_MOD;
			"^": k = gqt_pkg::K_XOR;
			default: k = gqt_pkg::K_ERR;
		endcase
		add_token(k, m_off, 1, m_line, m_col);
	endtask

	function automatic void pair_close(logic [5:0] k);
		m_len = 2; add_open(k); m_mode = LX_IDLE;
	endfunction

	function automatic bit extend_open(logic [7:0] c);
		logic [7:0] qc;
		qc = m_dq ? "\"" : "'";
		case (m_mode)
			LX_SLASH: begin
				if (c == "/") begin m_mode = LX_COMMENT; return 1; end
				add_open(gqt_pkg::K_DIV); return 0;
			end
			LX_COMMENT: begin
				if (c == "\n") m_mode = LX_IDLE;
				return 1;
			end
			LX_IDENT: begin
				if (is_word(c)) begin
					narrow_hits(c); m_len = sat(m_len, 1, gqt_pkg::SAT16); return 1;
				end
				add_open(word_kind()); return 0;
			end
			LX_PARAM: begin
				if (is_word(c)) begin m_len = sat(m_len, 1, gqt_pkg::SAT16); return 1; end
				add_open(gqt_pkg::K_PARAM); return 0;
			end
			LX_MINUS: begin
				if (is_digit(c)) begin m_len = 2; m_mode = LX_INT; return 1; end
				if (c == ">") begin pair_close(gqt_pkg::K_ARROW); return 1; end
				add_open(gqt_pkg::K_MINUS); return 0;
			end
			LX_INT: begin
				if (is_digit(c)) begin m_len = sat(m_len, 1, gqt_pkg::SAT16); return 1; end
				if (c == ".") begin m_mode = LX_INT_DOT; return 1; end
				add_open(gqt_pkg::K_INT); return 0;
			end
			LX_INT_DOT: begin
				if (is_digit(c)) begin
					m_len = sat(m_len, 2, gqt_pkg::SAT16); m_mode = LX_FLOAT; return 1;
				end
				int_and_dot(); return 0;
			end
			LX_FLOAT: begin
				if (is_digit(c)) begin m_len = sat(m_len, 1, gqt_pkg::SAT16); return 1; end
				add_open(gqt_pkg::K_FLOAT); return 0;
			end
			LX_STRING: begin
				if (c == qc && !m_esc) begin
					add_token(gqt_pkg::K_STR, sat(m_start, 1, gqt_pkg::OFF_LIM), m_len, m_tline,
						sat(m_tcol, 1, gqt_pkg::SAT16));
					m_mode = LX_IDLE;
					return 1;
				end
				m_esc = (c == "\\");
				m_len = sat(m_len, 1, gqt_pkg::SAT16);
				return 1;
			end
			LX_EQ: begin
				if (c == "=") begin pair_close(gqt_pkg::K_EQ); return 1; end
				add_open(gqt_pkg::K_EQ); return 0;
			end
			LX_BANG: begin
				if (c == "=") begin pair_close(gqt_pkg::K_NE); return 1; end
				add_open(gqt_pkg::K_NOT); return 0;
			end
			LX_LT: begin
				if (c == "=") begin pair_close(gqt_pkg::K_LE); return 1; end
				if (c == "-") begin pair_close(gqt_pkg::K_ARROW); return 1; end
				add_open(gqt_pkg::K_LT); return 0;
			end
			LX_GT: begin
				if (c == "=") begin pair_close(gqt_pkg::K_GE); return 1; end
				add_open(gqt_pkg::K_GT); return 0;
			end
			default: return 0;
		endcase
	endfunction

	task automatic flush_open();
		case (m_mode)
			LX_SLASH: add_open(gqt_pkg::K_DIV);
			LX_IDENT: add_open(word_kind());
			LX_PARAM: add_open(gqt_pkg::K_PARAM);
			LX_MINUS: add_open(gqt_pkg::K_MINUS);
			LX_INT: add_open(gqt_pkg::K_INT);
			LX_INT_DOT: int_and_dot();
			LX_FLOAT: add_open(gqt_pkg::K_FLOAT);
			LX_STRING: add_token(gqt_pkg::K_ERR, m_start, sat(m_len, 1, gqt_pkg::SAT16),
				m_tline, m_tcol);
			LX_EQ: add_open(gqt_pkg::K_EQ);
			LX_BANG: add_open(gqt_pkg::K_NOT);
			LX_LT: add_open(gqt_pkg::K_LT);
			LX_GT: add_open(gqt_pkg::K_GT);
			default: ;
		endcase
	endtask

	task automatic tokenize_item(text_item_t it);
		m_out.delete();
		if (it.valid) begin
			if (m_mode == LX_IDLE || !extend_open(it.ch)) scan_fresh(it.ch);
			m_off = sat(m_off, 1, gqt_pkg::OFF_LIM);
			if (it.ch == "\n") begin
				m_line = sat(m_line, 1, gqt_pkg::SAT16); m_col = 1;
			end else begin
				m_col = sat(m_col, 1, gqt_pkg::SAT16);
			end
		end
		if (it.fin) begin
			flush_open();
			add_token(gqt_pkg::K_EOF, m_off, 0, m_line, m_col);
			lex_reset();
		end
		if (m_out.size() > 0) m_out[m_out.size() - 1].last = 1;
		foreach (m_out[i]) token_queue.push_back(m_out[i]);
	endtask

	task automatic add_text(string s, bit fin);
		for (int i = 0; i < s.len(); i++)
			pending_items.push_back('{s[i], 1'b1, fin && i == s.len() - 1});
	endtask

	task automatic add_raw(logic [7:0] c, logic v, logic f);
		pending_items.push_back('{c, v, f});
	endtask

	function automatic string pick_piece();
		string ops[] = '{"(", ")", "[", "]", "{", "}", ",", ";", ":", "|", "@", ".", "*", "+",
			"/", "%", "=", "==", "!=", "!", "<", "<=", ">", ">=", "->", "<-", "-", "^", "<>"};
		string s;
		int n;
		case ($urandom_range(0, 11))
			0, 1: return kw_name($urandom_range(0, 41));
			2: begin
				s = "";
				n = $urandom_range(1, 6);
				for (int i = 0; i < n; i++) s = {s, string'(8'($urandom_range("a", "z")))};
				return s;
			end
			3: return $sformatf("%0d", $urandom_range(0, 99999));
			4: return $sformatf("%0d.%0d", $urandom_range(0, 999), $urandom_range(0, 99));
			5: return $sformatf("-%0d", $urandom_range(0, 999));
			6: return $urandom_range(0, 1) ? "'ab\\'c'" : "\"x y\\\\\"";
			7: return $sformatf("$p%0d", $urandom_range(0, 99));
			8: return "// note\n";
			9: return $sformatf("%0d.x", $urandom_range(0, 9));
			default: return ops[$urandom_range(0, ops.size() - 1)];
		endcase
	endfunction

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(negedge clk) begin
		if (arst_n && !(push && !took)) begin
			if (took) pending_items.pop_front();
			if (gap_left > 0) gap_left--;
			else if (!quiet && $urandom_range(0, 7) == 0) gap_left = $urandom_range(1, 4);
			if (pending_items.size() > 0 && gap_left == 0 && !hold_push) begin
				push <= 1;
				{in_byte, byte_valid, end_of_input} <= pending_items[0];
			end else begin
				push <= 0;
			end
		end
		if (stall_left > 0) stall_left--;
		else if (!quiet && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 4);
		pop <= (stall_left == 0);
	end

	always @(posedge clk) begin
		lex_token_t want;
		cycles++;
		took = arst_n && push && !full;
		if (took) tokenize_item(pending_items[0]);
		if (arst_n && pop && !empty) begin
			if (token_queue.size() == 0) begin
				errors++;
				$display("%0t: unexpected token kind %0d", $time, token_kind);
			end else begin
				want = token_queue.pop_front();
				if (want != {token_kind, token_offset, token_length, token_line, token_column,
						last_of_run}) begin
					errors++;
					$display("%0t: expected %0d/%0d/%0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d/%0d/%0d",
						$time, want.kind, want.offset, want.length, want.line, want.column,
						want.last, token_kind, token_offset, token_length, token_line,
						token_column, last_of_run);
				end
			end
		end
		if (cycles > 200000) begin
			$display("graph_query_tokenizer test failed");
			$finish;
		end
	end

	initial begin
		int n;
		string s;
		arst_n = 0; push = 0; pop = 0; in_byte = 0; byte_valid = 0; end_of_input = 0;
		lex_lreset_wrap();
		repeat (3) @(posedge clk);
		@(negedge clk) arst_n = 1;
		// directed part
		add_text("MATCH (n)-[r]->(m) WHERE a<=b RETURN count(x), -12, 3.5, 7.x 'it\\'s'", 0);
		add_raw(8'hff, 1, 0);
		add_raw(8'h00, 1, 0);
		add_raw(8'h55, 0, 0);
		add_text("$p1 != !a ^ 1.", 0);
		add_raw(8'h00, 0, 1);
		add_text("x // c\n\"open", 1);
		add_text("relationships startNode COALESCE OPTIONAL DISTINCT collect properties", 1);
		wait (pending_items.size() == 0 && token_queue.size() == 0);
		hold_push = 1;
		repeat (4) @(posedge clk);
		hold_push = 0;
		// random queries
		n = 0;
		while (n < 140) begin
			s = pick_piece();
			if ($urandom_range(0, 2) != 0) s = {s, $urandom_range(0, 5) == 0 ? "\n" : " "};
			if ($urandom_range(0, 20) == 0) add_raw(8'($urandom_range(128, 255)), 1, 0);
			if ($urandom_range(0, 25) == 0) add_raw(8'($urandom), 0, 0);
			add_text(s, $urandom_range(0, 12) == 0);
			n += s.len();
			if (n > 110) quiet = 1;
		end
		add_raw(8'($urandom), 1, 1);
		wait (pending_items.size() == 0 && token_queue.size() == 0);
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("graph_query_tokenizer test passed");
		else
			$display("graph_query_tokenizer test failed");
		$finish;
	end

	task automatic lex_lreset_wrap();
		lex_reset();
	endtask
endmodule
